@@ hdl/blm_pkg.sv @@
// blm_pkg: shared constants, register codes and types of the battery level monitor.
// No dependencies. Used by blm_serdiv, battery_level_monitor, blm_checker and the testbench.

package blm_pkg;

    // field widths
    localparam int unsigned VOLT_W    = 16;
    localparam int unsigned LEVEL_W   = 13;
    localparam int unsigned FRAC_W    = 10;   // quotient bits inside one level segment
    localparam int unsigned DIV_CNT_W = 5;    // step counter of the serial divider

    // default moving-average depth
    localparam int unsigned AVERAGE_DEPTH_DEF = 8;

    // configuration port
    localparam int unsigned NUM_CFG   = 6;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;

    // register indexes (byte address is 4 * index)
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_END       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUARTER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_QUARTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARGED       = 3'd5;

    // register reset values, millivolts
    localparam logic [VOLT_W-1:0] RST_CUT_START     = 16'd34000;
    localparam logic [VOLT_W-1:0] RST_CUT_END       = 16'd31000;
    localparam logic [VOLT_W-1:0] RST_QUARTER       = 16'd36000;
    localparam logic [VOLT_W-1:0] RST_HALF          = 16'd38000;
    localparam logic [VOLT_W-1:0] RST_THREE_QUARTER = 16'd40000;
    localparam logic [VOLT_W-1:0] RST_CHARGED       = 16'd42000;

    // Q12 full level
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 13'd4096;

    // divider start request
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_req;

endpackage

@@ hdl/blm_ram.sv @@
// blm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.

module blm_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/blm_serdiv.sv @@
// blm_serdiv: restoring divider, one quotient bit per cycle.
// Depends on blm_pkg (t_div_req, VOLT_W, DIV_CNT_W).

module blm_serdiv #(
    parameter int unsigned SW = 19
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  blm_pkg::t_div_req         i_req,
    input  logic [SW-1:0]             i_rem,    // partial remainder preload
    input  logic [SW-1:0]             i_dvd,    // dividend bits, shifted in MSB first
    input  logic [SW-1:0]             i_den,
    output logic                      o_done,
    output logic [blm_pkg::VOLT_W-1:0] o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [blm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [SW-1:0]                 r_rem;
    logic [SW-1:0]                 r_dvd;
    logic [SW-1:0]                 r_den;
    logic [blm_pkg::VOLT_W-1:0]    r_quo;

    logic [SW:0]   trial;
    logic          fits;
    logic [SW-1:0] n_rem;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        trial = {r_rem, r_dvd[SW-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? SW'(trial - {1'b0, r_den}) : trial[SW-1:0];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == blm_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_rem;
            r_dvd <= i_dvd;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[SW-2:0], 1'b0};
            r_quo <= {r_quo[blm_pkg::VOLT_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ hdl/battery_level_monitor.sv @@
// battery_level_monitor: moving-average battery monitor with low-battery hysteresis
// and a four-segment Q12 charge level. Depends on blm_pkg, blm_ram, blm_serdiv.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | i_voltage_mv, i_motor_off
//  out     | output    | o_out_valid/ i_out_stall| o_average_mv, o_low_battery,
//          |           |                         | o_battery_level, o_updated
//  cfg     | input     | psel/penable/pready     | paddr, pwdata, prdata
//
// A sample with the motor running goes from the idle state straight to the done state and
// on to the output register. A sample with the motor off runs the shared bit-serial divider,
// SW = 16 + clog2(AVERAGE_DEPTH) bits wide, once for the average and, unless the level is a
// special case, once more for the ten fraction bits of the level. One item is in work at a
// time; a finished result waits in the output register while the next item is taken. Reset
// is synchronous and leaves the ring reading as zero (a wrap flag masks entries not yet written).

module battery_level_monitor #(
    parameter int unsigned AVERAGE_DEPTH = blm_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [blm_pkg::VOLT_W-1:0]         i_voltage_mv,
    input  logic                               i_motor_off,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [blm_pkg::VOLT_W-1:0]         o_average_mv,
    output logic                               o_low_battery,
    output logic [blm_pkg::LEVEL_W-1:0]        o_battery_level,
    output logic                               o_updated,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [blm_pkg::ADDR_W-1:0]         paddr,
    input  logic [blm_pkg::DATA_W-1:0]         pwdata,
    output logic [blm_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    localparam int unsigned SW = blm_pkg::VOLT_W + $clog2(AVERAGE_DEPTH);
    localparam int unsigned NW = $clog2(AVERAGE_DEPTH + 1);
    localparam int unsigned PW = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
    localparam logic [NW-1:0] DEPTH_N  = NW'(AVERAGE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR = PW'(AVERAGE_DEPTH - 1);
    localparam logic [blm_pkg::DIV_CNT_W-1:0] AVG_STEPS = blm_pkg::DIV_CNT_W'(SW);
    localparam logic [blm_pkg::DIV_CNT_W-1:0] LVL_STEPS = blm_pkg::DIV_CNT_W'(blm_pkg::FRAC_W);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_CMP  = 8'b0000_1000,
        S_SEG  = 8'b0001_0000,
        S_AVG  = 8'b0010_0000,
        S_LVL  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [blm_pkg::VOLT_W-1:0] r_cut_start, r_cut_end, r_quarter, r_half;
    logic [blm_pkg::VOLT_W-1:0] r_three_quarter, r_charged;
    logic                       cfg_wr;
    logic [blm_pkg::CFG_IDX_W-1:0] cfg_idx;

    // filter state
    logic [PW-1:0]              r_ptr;
    logic                       r_wrapped;
    logic [SW-1:0]              r_sum;
    logic [blm_pkg::VOLT_W-1:0] r_avg;
    logic                       r_low;
    logic [blm_pkg::LEVEL_W-1:0] r_level;

    // per-item working registers
    logic [blm_pkg::VOLT_W-1:0]    r_v;
    logic                          r_upd;
    logic [blm_pkg::CFG_IDX_W-1:0] r_mcnt;
    logic [SW-1:0]                 r_prod [blm_pkg::NUM_CFG];
    logic [SW-1:0]                 r_lo, r_hi, r_diff, r_den;
    logic [1:0]                    r_seg;
    logic                          r_special;
    logic [blm_pkg::LEVEL_W-1:0]   r_spec_level;

    // output registers
    logic                        r_out_valid;
    logic [blm_pkg::VOLT_W-1:0]  r_out_avg;
    logic                        r_out_low;
    logic [blm_pkg::LEVEL_W-1:0] r_out_level;
    logic                        r_out_upd;

    // combinational helpers
    logic                       in_xfer;
    logic                       out_free;
    logic [blm_pkg::VOLT_W-1:0] ram_rdata;
    logic [blm_pkg::VOLT_W-1:0] old_sample;
    logic [blm_pkg::VOLT_W-1:0] thr;
    logic [SW-1:0]              n_prod;
    logic                       n_low;
    logic                       flat, below, above;

    // divider hookup
    blm_pkg::t_div_req          div_req;
    logic [SW-1:0]              div_rem, div_dvd, div_den;
    logic                       div_done;
    logic [blm_pkg::VOLT_W-1:0] div_quo;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[blm_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_start     <= blm_pkg::RST_CUT_START;
            r_cut_end       <= blm_pkg::RST_CUT_END;
            r_quarter       <= blm_pkg::RST_QUARTER;
            r_half          <= blm_pkg::RST_HALF;
            r_three_quarter <= blm_pkg::RST_THREE_QUARTER;
            r_charged       <= blm_pkg::RST_CHARGED;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                blm_pkg::CFG_CUT_START:     r_cut_start     <= pwdata[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_CUT_END:       r_cut_end       <= pwdata[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_QUARTER:       r_quarter       <= pwdata[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_HALF:          r_half          <= pwdata[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_THREE_QUARTER: r_three_quarter <= pwdata[blm_pkg::VOLT_W-1:0];
                blm_pkg::CFG_CHARGED:       r_charged       <= pwdata[blm_pkg::VOLT_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            blm_pkg::CFG_CUT_START:     prdata[blm_pkg::VOLT_W-1:0] = r_cut_start;
            blm_pkg::CFG_CUT_END:       prdata[blm_pkg::VOLT_W-1:0] = r_cut_end;
            blm_pkg::CFG_QUARTER:       prdata[blm_pkg::VOLT_W-1:0] = r_quarter;
            blm_pkg::CFG_HALF:          prdata[blm_pkg::VOLT_W-1:0] = r_half;
            blm_pkg::CFG_THREE_QUARTER: prdata[blm_pkg::VOLT_W-1:0] = r_three_quarter;
            blm_pkg::CFG_CHARGED:       prdata[blm_pkg::VOLT_W-1:0] = r_charged;
            default: ;
        endcase
    end

    // ---------------- sample ring ----------------
    blm_ram #(
        .WIDTH (blm_pkg::VOLT_W),
        .DEPTH (AVERAGE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == S_READ),
        .i_waddr (r_ptr),
        .i_wdata (r_v),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // entries not yet written read as zero until the first wrap
    assign old_sample = r_wrapped ? ram_rdata : '0;

    // ---------------- threshold scaling ----------------
    always_comb begin
        case (r_mcnt)
            blm_pkg::CFG_CUT_START:     thr = r_cut_start;
            blm_pkg::CFG_CUT_END:       thr = r_cut_end;
            blm_pkg::CFG_QUARTER:       thr = r_quarter;
            blm_pkg::CFG_HALF:          thr = r_half;
            blm_pkg::CFG_THREE_QUARTER: thr = r_three_quarter;
            default:                    thr = r_charged;
        endcase
        n_prod = SW'(thr) * SW'(DEPTH_N);
    end

    // hysteresis: clear above cut_start, then set below cut_end
    always_comb begin
        n_low = r_low && !(r_sum > r_prod[blm_pkg::CFG_CUT_START]);
        n_low = n_low || (r_sum < r_prod[blm_pkg::CFG_CUT_END]);
    end

    // segment special cases
    assign flat  = (r_hi <= r_lo);
    assign below = (r_sum < r_lo);
    assign above = (r_sum >= r_hi);

    // ---------------- divider ----------------
    always_comb begin
        div_req.start = (r_state == S_CMP) || ((r_state == S_AVG) && div_done && !r_special);
        div_req.steps = (r_state == S_CMP) ? AVG_STEPS : LVL_STEPS;
        if (r_state == S_CMP) begin
            div_rem = '0;
            div_dvd = r_sum;
            div_den = SW'(DEPTH_N);
        end else begin
            div_rem = r_diff;
            div_dvd = '0;
            div_den = r_den;
        end
    end

    blm_serdiv #(
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_rem   (div_rem),
        .i_dvd   (div_dvd),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_xfer) n_state = i_motor_off ? S_READ : S_DONE;
            S_READ: n_state = S_MUL;
            S_MUL:  if (r_mcnt == blm_pkg::CFG_CHARGED) n_state = S_CMP;
            S_CMP:  n_state = S_SEG;
            S_SEG:  n_state = S_AVG;
            S_AVG:  if (div_done) n_state = r_special ? S_DONE : S_LVL;
            S_LVL:  if (div_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_wrapped   <= 1'b0;
            r_sum       <= '0;
            r_avg       <= '0;
            r_low       <= 1'b0;
            r_level     <= blm_pkg::LEVEL_FULL;
            r_out_valid <= 1'b0;
            r_mcnt      <= '0;
        end else begin
            r_state <= n_state;
            // ring update
            if (r_state == S_READ) begin
                r_sum <= SW'(r_sum - SW'(old_sample) + SW'(r_v));
                if (r_ptr == LAST_PTR) begin
                    r_ptr     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            // threshold counter
            if (r_state == S_READ) begin
                r_mcnt <= '0;
            end else if (r_state == S_MUL) begin
                r_mcnt <= r_mcnt + 1'b1;
            end
            if (r_state == S_CMP) begin
                r_low <= n_low;
            end
            if ((r_state == S_AVG) && div_done) begin
                r_avg <= div_quo;
                if (r_special) begin
                    r_level <= r_spec_level;
                end
            end
            if ((r_state == S_LVL) && div_done) begin
                r_level <= {1'b0, r_seg, div_quo[blm_pkg::FRAC_W-1:0]};
            end
            // output register
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_v   <= i_voltage_mv;
            r_upd <= i_motor_off;
        end
        if (r_state == S_MUL) begin
            r_prod[r_mcnt] <= n_prod;
        end
        // pick the segment from the scaled sum
        if (r_state == S_CMP) begin
            if (r_sum >= r_prod[blm_pkg::CFG_THREE_QUARTER]) begin
                r_lo  <= r_prod[blm_pkg::CFG_THREE_QUARTER];
                r_hi  <= r_prod[blm_pkg::CFG_CHARGED];
                r_seg <= 2'd3;
            end else if (r_sum >= r_prod[blm_pkg::CFG_HALF]) begin
                r_lo  <= r_prod[blm_pkg::CFG_HALF];
                r_hi  <= r_prod[blm_pkg::CFG_THREE_QUARTER];
                r_seg <= 2'd2;
            end else if (r_sum >= r_prod[blm_pkg::CFG_QUARTER]) begin
                r_lo  <= r_prod[blm_pkg::CFG_QUARTER];
                r_hi  <= r_prod[blm_pkg::CFG_HALF];
                r_seg <= 2'd1;
            end else begin
                r_lo  <= r_prod[blm_pkg::CFG_CUT_START];
                r_hi  <= r_prod[blm_pkg::CFG_QUARTER];
                r_seg <= 2'd0;
            end
        end
        // segment offset and span; top value when flat or past the top, zero below
        if (r_state == S_SEG) begin
            r_diff    <= r_sum - r_lo;
            r_den     <= r_hi - r_lo;
            r_special <= flat || below || above;
            if (flat || !below) begin
                r_spec_level <= {{1'b0, r_seg} + 3'd1, {blm_pkg::FRAC_W{1'b0}}};
            end else begin
                r_spec_level <= '0;
            end
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out_avg   <= r_avg;
            r_out_low   <= r_low;
            r_out_level <= r_level;
            r_out_upd   <= r_upd;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_average_mv    = r_out_avg;
    assign o_low_battery   = r_out_low;
    assign o_battery_level = r_out_level;
    assign o_updated       = r_out_upd;

endmodule

@@ hdl/blm_checker.sv @@
// blm_checker: port-level checks of battery_level_monitor, bound to the top level.
// Depends on blm_pkg and battery_level_monitor.

module blm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic [blm_pkg::VOLT_W-1:0]         o_average_mv,
    input logic                               o_low_battery,
    input logic [blm_pkg::LEVEL_W-1:0]        o_battery_level,
    input logic                               o_updated
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_average_mv)
            && $stable(o_low_battery) && $stable(o_battery_level) && $stable(o_updated))
        else $error("stalled result changed");

    // level never leaves the Q12 range
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_battery_level <= blm_pkg::LEVEL_FULL)
        else $error("level above full scale");

    // one item at a time: a transfer makes the block busy
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before result");

    // reset empties the output and readies the input
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

@@ tb/sv/battery_level_monitor_test.sv @@
// battery_level_monitor_test: self-checking testbench of the battery level monitor.
// Depends on blm_pkg and the battery_level_monitor RTL. Drives samples, register writes
// and random stalls, and checks each result against a built-in filter predictor or a typed row's want.

module battery_level_monitor_test;
    import blm_pkg::*;

    localparam int DEPTH           = 8;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 60;
    localparam int PHASE_ITEMS     = 72;
    localparam int NUM_ROWS        = 23;
    // address past the last register; a write there must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

    typedef struct packed {
        logic [VOLT_W-1:0]  average_mv;
        logic               low_battery;
        logic [LEVEL_W-1:0] battery_level;
        logic               updated;
    } monitor_result_t;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_mv;
        logic              motor_off;
        logic              typed;      // compare with want instead of the predictor
        monitor_result_t   want;
    } stim_row_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    localparam monitor_result_t NO_WANT = '0;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [VOLT_W-1:0]   i_voltage_mv = '0;
    logic                i_motor_off = 1'b0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [VOLT_W-1:0]   o_average_mv;
    logic                o_low_battery;
    logic [LEVEL_W-1:0]  o_battery_level;
    logic                o_updated;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // predictor state and register copy
    logic [VOLT_W-1:0]   cfg_mv [NUM_CFG];
    logic [VOLT_W-1:0]   sample_hist [DEPTH];
    int unsigned         hist_slot;
    longint              hist_sum;
    monitor_result_t     held;

    monitor_result_t     expected_results [$];
    int                  error_count = 0;
    int                  idle_cycles = 0;
    int                  burst_left = 0;
    bit                  hold_off_req = 1'b0;
    stall_mode_t         stall_mode = STALL_NONE;
    int                  stall_left = 0;
    int                  stall_tick = 0;

    // directed samples: rails, ring fill, motor running, every threshold
    stim_row_t directed_rows [NUM_ROWS] = '{
        {16'hFFFF, 1'b0, 1'b1, 16'd0,     1'b0, LEVEL_FULL, 1'b0},
        {16'h0000, 1'b1, 1'b1, 16'd0,     1'b1, 13'd0,      1'b1},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b0, NO_WANT},
        {16'hFFFF, 1'b1, 1'b1, 16'd65535, 1'b0, LEVEL_FULL, 1'b1},
        {16'h0000, 1'b0, 1'b1, 16'd65535, 1'b0, LEVEL_FULL, 1'b0},
        {16'd36000, 1'b1, 1'b0, NO_WANT},
        {16'd38000, 1'b1, 1'b0, NO_WANT},
        {16'd40000, 1'b1, 1'b0, NO_WANT},
        {16'd42000, 1'b1, 1'b0, NO_WANT},
        {16'd34000, 1'b1, 1'b0, NO_WANT},
        {16'd31000, 1'b1, 1'b0, NO_WANT},
        {16'd30999, 1'b1, 1'b0, NO_WANT},
        {16'd34001, 1'b1, 1'b0, NO_WANT},
        {16'd0,     1'b1, 1'b0, NO_WANT},
        {16'd0,     1'b1, 1'b0, NO_WANT},
        {16'd1,     1'b1, 1'b0, NO_WANT},
        {16'd42000, 1'b0, 1'b0, NO_WANT}
    };

    battery_level_monitor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_voltage_mv    (i_voltage_mv),
        .i_motor_off     (i_motor_off),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_average_mv    (o_average_mv),
        .o_low_battery   (o_low_battery),
        .o_battery_level (o_battery_level),
        .o_updated       (o_updated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #2 i_clk = ~i_clk;

    // level inside one segment, floor division; bounds not rising give the top value
    function automatic longint segment_level(longint total, longint lo, longint hi,
                                             longint base);
        longint num;
        longint den;
        longint q;
        if (hi <= lo) return base + 1024;
        num = (total - lo * DEPTH) * 1024;
        den = (hi - lo) * DEPTH;
        q = num / den;
        if (num % den != 0 && num < 0) q = q - 1;
        return base + q;
    endfunction

    // advance the filter by one sample and return the result it gives
    function automatic monitor_result_t filter_sample(logic [VOLT_W-1:0] v, logic take);
        longint lim [NUM_CFG];
        longint lvl;
        for (int k = 0; k < NUM_CFG; k++) lim[k] = longint'(cfg_mv[k]) * DEPTH;
        if (take) begin
            hist_sum = hist_sum - sample_hist[hist_slot] + v;
            sample_hist[hist_slot] = v;
            hist_slot = (hist_slot + 1) % DEPTH;
            held.average_mv = VOLT_W'(hist_sum / DEPTH);
            // clear is tested before set
            if (held.low_battery && hist_sum > lim[CFG_CUT_START]) held.low_battery = 1'b0;
            if (!held.low_battery && hist_sum < lim[CFG_CUT_END]) held.low_battery = 1'b1;
            if (hist_sum >= lim[CFG_THREE_QUARTER])
                lvl = segment_level(hist_sum, cfg_mv[CFG_THREE_QUARTER], cfg_mv[CFG_CHARGED],
                                    3072);
            else if (hist_sum >= lim[CFG_HALF])
                lvl = segment_level(hist_sum, cfg_mv[CFG_HALF], cfg_mv[CFG_THREE_QUARTER], 2048);
            else if (hist_sum >= lim[CFG_QUARTER])
                lvl = segment_level(hist_sum, cfg_mv[CFG_QUARTER], cfg_mv[CFG_HALF], 1024);
            else
                lvl = segment_level(hist_sum, cfg_mv[CFG_CUT_START], cfg_mv[CFG_QUARTER], 0);
            if (lvl < 0) lvl = 0;
            if (lvl > 4096) lvl = 4096;
            held.battery_level = LEVEL_W'(lvl);
        end
        held.updated = take;
        return held;
    endfunction

    // one input transfer; called and returns at a falling edge
    task automatic send_item(input logic [VOLT_W-1:0] v, input logic take, input logic typed,
                             input monitor_result_t want);
        monitor_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_voltage_mv <= v;
        i_motor_off  <= take;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = filter_sample(v, take);
        expected_results.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one APB transfer; a read is checked against the register copy
    task automatic apb_access(input logic write, input logic [CFG_IDX_W-1:0] idx,
                              input logic [VOLT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W - VOLT_W){1'b0}}, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx < NUM_CFG) begin
            if (write) begin
                cfg_mv[idx] = value;
            end else if (prdata[VOLT_W-1:0] !== cfg_mv[idx]) begin
                $display("%0t: register %0d read back: expected %0d actual %0d",
                         $time, idx, cfg_mv[idx], prdata[VOLT_W-1:0]);
                error_count++;
            end
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_regs(input logic [VOLT_W-1:0] start_mv, end_mv, quarter,
                                half, three_quarter, charged);
        apb_access(1'b1, CFG_CUT_START, start_mv);
        apb_access(1'b1, CFG_CUT_END, end_mv);
        apb_access(1'b1, CFG_QUARTER, quarter);
        apb_access(1'b1, CFG_HALF, half);
        apb_access(1'b1, CFG_THREE_QUARTER, three_quarter);
        apb_access(1'b1, CFG_CHARGED, charged);
        for (int k = 0; k < NUM_CFG; k++) apb_access(1'b0, CFG_IDX_W'(k), '0);
    endtask

    // Runs of samples around one register value, so that the average settles across
    // thresholds, mixed with noise runs of any voltage or the rails.
    task automatic run_random(input int count, input bit with_hold);
        int sent;
        int run_left;
        int t;
        bit noise;
        bit hold_done;
        logic take;
        logic [VOLT_W-1:0] target;
        logic [VOLT_W-1:0] v;
        sent = 0;
        run_left = 0;
        hold_done = 0;
        noise = 0;
        target = '0;
        while (sent < count) begin
            if (run_left == 0) begin
                target = cfg_mv[$urandom_range(0, NUM_CFG - 1)];
                run_left = $urandom_range(4, 12);
                noise = ($urandom_range(0, 9) >= 7);
            end
            run_left--;
            if (noise) begin
                if ($urandom_range(0, 3) == 0) v = $urandom_range(0, 1) ? '1 : '0;
                else v = VOLT_W'($urandom_range(0, 65535));
            end else begin
                t = int'(target) + int'($urandom_range(0, 800)) - 400;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                v = VOLT_W'(t);
            end
            take = ($urandom_range(0, 7) != 0);
            // long receiver hold-off while items keep coming
            if (with_hold && !hold_done && sent >= 20) begin
                hold_off_req = 1'b1;
                hold_done = 1;
            end
            send_item(v, take, 1'b0, NO_WANT);
            if (take) sent++;
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_off_req) begin
            hold_off_req = 1'b0;
            i_out_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        end else begin
            if (stall_left == 0) begin
                stall_mode = stall_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(20, 80);
            end
            stall_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     i_out_stall <= 1'b0;
                STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: i_out_stall <= (stall_tick % 3 == 0);
                default:        i_out_stall <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    // result checker: each output transfer against the oldest expectation
    always @(posedge i_clk) begin
        monitor_result_t got;
        monitor_result_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_average_mv, o_low_battery, o_battery_level, o_updated};
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: avg %0d low %0b level %0d upd %0b",
                         $time, got.average_mv, got.low_battery, got.battery_level,
                         got.updated);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch: expected avg %0d low %0b level %0d upd %0b, %s",
                             $time, want.average_mv, want.low_battery, want.battery_level,
                             want.updated, "see actual below");
                    $display("%0t:           actual   avg %0d low %0b level %0d upd %0b",
                             $time, got.average_mv, got.low_battery, got.battery_level,
                             got.updated);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        cfg_mv[CFG_CUT_START]     = RST_CUT_START;
        cfg_mv[CFG_CUT_END]       = RST_CUT_END;
        cfg_mv[CFG_QUARTER]       = RST_QUARTER;
        cfg_mv[CFG_HALF]          = RST_HALF;
        cfg_mv[CFG_THREE_QUARTER] = RST_THREE_QUARTER;
        cfg_mv[CFG_CHARGED]       = RST_CHARGED;
        for (int k = 0; k < DEPTH; k++) sample_hist[k] = '0;
        hist_slot = 0;
        hist_sum  = 0;
        held      = {16'd0, 1'b0, LEVEL_FULL, 1'b0};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r])
            send_item(directed_rows[r].voltage_mv, directed_rows[r].motor_off,
                      directed_rows[r].typed, directed_rows[r].want);
        drain_results();

        // reset thresholds, with the long hold-off
        run_random(PHASE_ITEMS, 1'b1);
        drain_results();

        // all zero: every segment degenerate; plus a write past the last register
        program_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        apb_access(1'b1, CFG_UNUSED, 16'h5A5A);
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        // all at full scale
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        // misordered hysteresis, reversed and equal segment bounds
        program_regs(16'd30000, 16'd40000, 16'd38000, 16'd36000, 16'd36000, 16'd33000);
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        // narrow, low-voltage map with an empty second segment
        program_regs(16'd3000, 16'd2800, 16'd3400, 16'd3400, 16'd3600, 16'd4200);
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        program_regs(VOLT_W'($urandom_range(0, 65535)), VOLT_W'($urandom_range(0, 65535)),
                     VOLT_W'($urandom_range(0, 65535)), VOLT_W'($urandom_range(0, 65535)),
                     VOLT_W'($urandom_range(0, 65535)), VOLT_W'($urandom_range(0, 65535)));
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        program_regs(RST_CUT_START, RST_CUT_END, RST_QUARTER, RST_HALF, RST_THREE_QUARTER,
                     RST_CHARGED);
        run_random(PHASE_ITEMS, 1'b0);
        drain_results();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
hdl/blm_pkg.sv
hdl/blm_ram.sv
hdl/blm_serdiv.sv
hdl/battery_level_monitor.sv
hdl/blm_checker.sv
tb/sv/battery_level_monitor_test.sv
